@@ design/efsa_pkg.sv @@
package efsa_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int TIME_BITS   = 32;
    localparam int SVC_BITS    = 16;
    localparam int CFG_BITS    = 5;
    localparam int IDX_BITS    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_CLEAR    = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [TIME_BITS-1:0] arrival_time;
        logic [SVC_BITS-1:0]  service_time;
    } req_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]  server_index;
        logic [TIME_BITS-1:0] wait_time;
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] departure_time;
    } rsp_t;

    // Write port of the free-time table.
    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  idx;
        logic [TIME_BITS-1:0] data;
    } tbl_wr_t;

endpackage

@@ design/efsa_table.sv @@
module efsa_table
    import efsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clr,
    input  tbl_wr_t              wr,
    input  logic [IDX_BITS-1:0]  rd_idx,
    output logic [TIME_BITS-1:0] rd_data
);

    logic [TIME_BITS-1:0] free_time_reg [MAX_SERVERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                free_time_reg[i] <= '0;
            end
        end
        else if (clr)
        begin
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                free_time_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            free_time_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = free_time_reg[rd_idx];

endmodule

@@ design/efsa_scan.sv @@
module efsa_scan
    import efsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  req_t                 req,
    input  logic [CFG_BITS-1:0]  count,
    input  logic [TIME_BITS-1:0] rd_data,
    output logic                 busy,
    output logic [IDX_BITS-1:0]  rd_idx,
    output tbl_wr_t              wr,
    output logic                 clr,
    output logic                 done,
    output rsp_t                 rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_CALC = 4'b0100,
        ST_ADD  = 4'b1000
    } state_t;

    localparam logic [CFG_BITS-1:0] MAX_CNT = CFG_BITS'(MAX_SERVERS);

    state_t               state_reg, state_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [IDX_BITS-1:0]  last_reg, last_next;
    logic [TIME_BITS-1:0] best_reg, best_next;
    logic [IDX_BITS-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] arr_reg, arr_next;
    logic [SVC_BITS-1:0]  svc_reg, svc_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] wait_reg, wait_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic [CFG_BITS-1:0]  cnt_clamped;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] depart;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign clr    = accept && (req.action == ACT_CLEAR);
    assign rd_idx = idx_reg;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // A count of zero still scans server 0; anything above the table size scans all.
    always_comb
    begin
        if (count == '0)
        begin
            cnt_clamped = CFG_BITS'(1);
        end
        else if (count > MAX_CNT)
        begin
            cnt_clamped = MAX_CNT;
        end
        else
        begin
            cnt_clamped = count;
        end
    end

    assign sum    = {1'b0, start_reg} + (TIME_BITS + 1)'(svc_reg);
    assign depart = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        arr_next      = arr_reg;
        svc_next      = svc_reg;
        start_next    = start_reg;
        wait_next     = wait_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;
        wr.en         = 1'b0;
        wr.idx        = best_idx_reg;
        wr.data       = depart;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.action == ACT_SCHEDULE))
                begin
                    arr_next   = req.arrival_time;
                    svc_next   = req.service_time;
                    idx_next   = '0;
                    last_next  = IDX_BITS'(cnt_clamped - CFG_BITS'(1));
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Strict less-than keeps the lowest index on ties.
                if ((idx_reg == '0) || (rd_data < best_reg))
                begin
                    best_next     = rd_data;
                    best_idx_next = idx_reg;
                end
                if (idx_reg == last_reg)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            ST_CALC:
            begin
                if (arr_reg >= best_reg)
                begin
                    start_next = arr_reg;
                    wait_next  = '0;
                end
                else
                begin
                    start_next = best_reg;
                    wait_next  = best_reg - arr_reg;
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                wr.en                   = 1'b1;
                rsp_next.server_index   = best_idx_reg;
                rsp_next.wait_time      = wait_reg;
                rsp_next.start_time     = start_reg;
                rsp_next.departure_time = depart;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        last_reg     <= last_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        arr_reg      <= arr_next;
        svc_reg      <= svc_next;
        start_reg    <= start_next;
        wait_reg     <= wait_next;
        rsp_reg      <= rsp_next;
    end

    a_done_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_ADD))
        else $error("result strobe without a completed schedule");

    a_wait_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.start_time - arr_reg == rsp_reg.wait_time))
        else $error("wait does not match start minus arrival");

    a_depart_not_early: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.departure_time >= rsp_reg.start_time))
        else $error("departure earlier than start");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rsp_reg.server_index <= last_reg))
        else $error("chosen server outside the scanned range");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= last_reg))
        else $error("scan index ran past the last server");

endmodule

@@ design/earliest_free_server_assign.sv @@
// Earliest-free-server assignment.
// A request is taken on a rising edge where start is high and busy is low.
// With action = schedule, the block scans the free times of the servers in
// use, one server per cycle through a single comparator, picks the earliest
// (lowest index on ties), and then reports server, wait, start and departure.
// The departure, saturated at the largest time, is written back as that
// server's new free time.
// A schedule request scans the N servers in use, N being the clamped
// servers_in_use (1..16), then passes the calc and add states before the
// done strobe. The next request can be accepted in the cycle the strobe
// is shown; none is taken while one is in flight.
// A clear request zeroes every free time at the accepting edge, gives no
// result and leaves busy low. Reset zeroes all free times and sets
// servers_in_use to one. done marks each result on rsp, high for a single
// cycle; rsp holds it to the next result; the receiver cannot stall it. cfg_we
// writes servers_in_use; the user must keep to idle, the block does not enforce it.
module earliest_free_server_assign
    import efsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    output logic                done,
    output rsp_t                rsp
);

    logic [CFG_BITS-1:0]  servers_in_use_reg;
    logic [TIME_BITS-1:0] rd_data;
    logic [IDX_BITS-1:0]  rd_idx;
    tbl_wr_t              wr;
    logic                 clr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servers_in_use_reg <= CFG_BITS'(1);
        end
        else if (cfg_we)
        begin
            servers_in_use_reg <= cfg_wdata;
        end
    end

    efsa_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (clr),
        .wr      (wr),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    efsa_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .count   (servers_in_use_reg),
        .rd_data (rd_data),
        .busy    (busy),
        .rd_idx  (rd_idx),
        .wr      (wr),
        .clr     (clr),
        .done    (done),
        .rsp     (rsp)
    );

endmodule
